// ----- hw/rtl/cmf_pkg.sv -----
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types and constants for the cross morphology filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cmf_pkg;

   // payload field widths
   localparam int PIXEL_W  = 8;
   localparam int OUT_ROW_W = 12;
   localparam int OUT_COL_W = 10;

   // configuration register widths and indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int FW_REG_W    = 11;
   localparam int FH_REG_W    = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [FW_REG_W-1:0] FW_RESET = 11'd1024;
   localparam logic [FH_REG_W-1:0] FH_RESET = 13'd1024;

   localparam logic MODE_EROSION  = 1'b0;
   localparam logic MODE_DILATION = 1'b1;

   localparam logic [PIXEL_W-1:0] PIXEL_ON  = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'd0;

   // smallest frame dimension
   localparam int MIN_DIM = 3;

   // result queue
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = 2;
   localparam int RQ_CNT_W = 3;

   typedef enum logic {
      ST_IDLE,
      ST_MUL
   } state_type;

   typedef struct packed {
      logic                 last;
      logic [OUT_COL_W-1:0] column;
      logic [OUT_ROW_W-1:0] row;
      logic [PIXEL_W-1:0]   pixel;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cross_morphology_filter.sv -----
// ----------------------------------------------------------------------------
// cross_morphology_filter
// Streaming 5-point cross erosion / dilation over a raster frame, with two
// line memories and a small result queue.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+--------------------------------
//  req_    | in        | tvalid / tready    | pixel, frame start flag
//  rsp_    | out       | tvalid / tready    | result pixel, row, column, last
//  csr_    | in        | we (no wait)       | mode, frame width, frame height
//
//  An interior pixel in erosion mode is read, then makes four passes
//  through the shared 8x8 multiplier; every other pixel is read, then
//  written back with its result. The line memories have a registered read
//  and are written in the cycle after the read.
//  Reset is synchronous and clears the position, the queue and the registers;
//  the line memories are not cleared. A stalled result side holds results in
//  a four-entry queue; a new pixel is taken only while idle and at least two slots are free.
//
`default_nettype none

module cross_morphology_filter #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [cmf_pkg::PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   input  wire logic                            req_tuser,   // [0] frame_start
   // response stream
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [31:0]                     rsp_tdata,   // [7:0] result_pixel,
                                                             // [19:8] out_row,
                                                             // [29:20] out_column
   output      logic                            rsp_tlast,   // last_of_run
   // configuration
   input  wire logic                            csr_we,
   input  wire logic [cmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cmf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cmf_pkg::*;

   localparam int AW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   // comparison widths cover both the register and the parameter
   localparam int WCW = ((WW > FW_REG_W) ? WW : FW_REG_W) + 1;
   localparam int HCW = ((HW > FH_REG_W) ? HW : FH_REG_W) + 1;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic                mode_ff;
   logic [FW_REG_W-1:0] fw_ff;
   logic [FH_REG_W-1:0] fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_EROSION;
         fw_ff   <= FW_RESET;
         fh_ff   <= FH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:         mode_ff <= csr_wdata[0];
            CSR_FRAME_WIDTH:  fw_ff   <= csr_wdata[FW_REG_W-1:0];
            CSR_FRAME_HEIGHT: fh_ff   <= csr_wdata[FH_REG_W-1:0];
            default:          ;
         endcase
      end
   end

   // clamp the frame dimensions into their legal ranges
   logic [WCW-1:0] w_use;
   logic [HCW-1:0] h_use;

   always_comb begin
      if (WCW'(fw_ff) < WCW'(MIN_DIM))
         w_use = WCW'(MIN_DIM);
      else if (WCW'(fw_ff) > WCW'(MAX_WIDTH))
         w_use = WCW'(MAX_WIDTH);
      else
         w_use = WCW'(fw_ff);
      if (HCW'(fh_ff) < HCW'(MIN_DIM))
         h_use = HCW'(MIN_DIM);
      else if (HCW'(fh_ff) > HCW'(MAX_HEIGHT))
         h_use = HCW'(MAX_HEIGHT);
      else
         h_use = HCW'(fh_ff);
   end

   // ------------------------------------------------------------------
   // control state
   // ------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [AW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [RQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RQ_PTR_W-1:0] wp_ff, wp_in;
   logic [RQ_PTR_W-1:0] rp_ff, rp_in;

   logic req_acc;
   logic rsp_acc;
   logic done;

   // ------------------------------------------------------------------
   // position of the incoming pixel
   // ------------------------------------------------------------------
   logic [WCW-1:0] c0, c1, c_next;
   logic [HCW-1:0] r0, r1, r2, r_next;
   logic           wrap_col;
   logic [WCW-1:0] c_right;
   logic [AW-1:0]  addr_c, addr_r, addr_l;
   logic           has_up, top_out, last_row, border;

   always_comb begin
      c0 = req_tuser ? '0 : WCW'(col_ff);
      r0 = req_tuser ? '0 : HCW'(row_ff);
      // a stale column beyond a narrowed width moves on to the next row
      if (c0 >= w_use) begin
         c1 = '0;
         r1 = r0 + HCW'(1);
      end else begin
         c1 = c0;
         r1 = r0;
      end
      r2 = (r1 >= h_use) ? '0 : r1;

      c_next   = c1 + WCW'(1);
      wrap_col = (c_next >= w_use);
      r_next   = r2 + HCW'(1);

      // memory addresses: centre, right and left neighbours
      c_right = c1 + WCW'(1);
      addr_c  = c1[AW-1:0];
      addr_r  = (c_right >= WCW'(MAX_WIDTH)) ? '0 : c_right[AW-1:0];
      addr_l  = (c1 == '0) ? '0 : AW'(c1 - WCW'(1));

      has_up   = (r2 != '0);
      top_out  = (r2 == HCW'(1));
      last_row = (r2 == h_use - HCW'(1));
      border   = (c1 == '0) || (c1 == w_use - WCW'(1));
   end

   // ------------------------------------------------------------------
   // line memories
   // ------------------------------------------------------------------
   logic [PIXEL_W-1:0] older_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] newer_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] ctr_ff, rt_ff, up_ff, lf_ff;
   logic               mem_we;

   // item held while it is worked on
   logic [PIXEL_W-1:0] pix_ff;
   logic [AW-1:0]      icol_ff;
   logic [RW-1:0]      irow_ff;
   logic               has_up_ff, last_row_ff, copy_ff, need_mul_ff;
   logic [PIXEL_W-1:0] acc_ff, acc_in;

   assign mem_we = (state_ff == ST_MUL) && (step_ff == 2'd0);

   always_ff @(posedge clock) begin
      // write back the row shift once per pixel: newer row drops to older
      if (mem_we) begin
         older_mem[icol_ff] <= ctr_ff;
         newer_mem[icol_ff] <= pix_ff;
      end
      if (req_acc) begin
         ctr_ff <= newer_mem[addr_c];
         rt_ff  <= newer_mem[addr_r];
         up_ff  <= older_mem[addr_c];
         lf_ff  <= older_mem[addr_l];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pix_ff      <= req_tdata;
         icol_ff     <= addr_c;
         irow_ff     <= r2[RW-1:0];
         has_up_ff   <= has_up;
         last_row_ff <= last_row;
         copy_ff     <= top_out || border;
         need_mul_ff <= has_up && !top_out && !border && (mode_ff == MODE_EROSION);
      end
      acc_ff <= acc_in;
   end

   // ------------------------------------------------------------------
   // shared 8x8 multiplier, low byte kept
   // ------------------------------------------------------------------
   logic [PIXEL_W-1:0]   mul_a, mul_b;
   logic [2*PIXEL_W-1:0] mul_p;
   logic [PIXEL_W-1:0]   dil_val;
   logic [PIXEL_W-1:0]   res_val;

   always_comb begin
      mul_a = (step_ff == 2'd0) ? ctr_ff : acc_ff;
      case (step_ff)
         2'd0:    mul_b = up_ff;
         2'd1:    mul_b = pix_ff;
         2'd2:    mul_b = lf_ff;
         2'd3:    mul_b = rt_ff;
         default: mul_b = up_ff;
      endcase
      mul_p   = mul_a * mul_b;
      acc_in  = mul_p[PIXEL_W-1:0];
      dil_val = ((ctr_ff | up_ff | pix_ff | lf_ff | rt_ff) != '0) ? PIXEL_ON : PIXEL_OFF;
      if (need_mul_ff)
         res_val = mul_p[PIXEL_W-1:0];
      else if (copy_ff)
         res_val = ctr_ff;
      else
         res_val = dil_val;
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign req_tready = (state_ff == ST_IDLE) && (cnt_ff <= RQ_CNT_W'(RQ_DEPTH - 2));
   assign req_acc    = req_tvalid && req_tready;
   assign done       = (state_ff == ST_MUL) && (!need_mul_ff || (step_ff == 2'd3));

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_MUL;
               step_in  = 2'd0;
               // advance the raster position
               if (wrap_col) begin
                  col_in = '0;
                  row_in = (r_next >= h_use) ? '0 : r_next[RW-1:0];
               end else begin
                  col_in = c_next[AW-1:0];
                  row_in = r2[RW-1:0];
               end
            end
         end
         ST_MUL: begin
            if (done) begin
               state_in = ST_IDLE;
               step_in  = 2'd0;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 2'd0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // result queue: up to two pushes per pixel, one pop per cycle
   // ------------------------------------------------------------------
   result_type rq_mem [RQ_DEPTH];
   result_type ent0, ent1, own_copy, filtered;
   logic [1:0] n_push;

   always_comb begin
      filtered.pixel  = res_val;
      filtered.row    = OUT_ROW_W'(irow_ff - RW'(1));
      filtered.column = OUT_COL_W'(icol_ff);
      filtered.last   = !last_row_ff;
      own_copy.pixel  = pix_ff;
      own_copy.row    = OUT_ROW_W'(irow_ff);
      own_copy.column = OUT_COL_W'(icol_ff);
      own_copy.last   = 1'b1;
      ent0   = has_up_ff ? filtered : own_copy;
      ent1   = own_copy;
      n_push = done ? (2'(has_up_ff) + 2'(last_row_ff)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0)
         rq_mem[wp_ff] <= ent0;
      if (n_push == 2'd2)
         rq_mem[wp_ff + RQ_PTR_W'(1)] <= ent1;
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {2'b00, rq_mem[rp_ff].column, rq_mem[rp_ff].row, rq_mem[rp_ff].pixel};
   assign rsp_tlast  = rq_mem[rp_ff].last;

   always_comb begin
      wp_in  = wp_ff + RQ_PTR_W'(n_push);
      rp_in  = rsp_acc ? (rp_ff + RQ_PTR_W'(1)) : rp_ff;
      cnt_in = cnt_ff + RQ_CNT_W'(n_push) - RQ_CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_rq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (32'(cnt_ff) + 32'(n_push) - 32'(rsp_acc)) <= RQ_DEPTH)
      else $error("result queue overflow");

   a_acc_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_MUL) && (step_ff == 2'd0))
      else $error("accepted pixel did not start processing");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == 2'd0))
      else $error("step counter left running in idle");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < MAX_WIDTH)
      else $error("column counter beyond line memory");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cross morphology filter. Streams raster frames
// through the request channel and predicts every tagged result with a model
// of the line stores kept inside a small scoreboard class. Results are
// checked in order, field by field. Both stream sides idle and stall at
// random, and the frame registers are swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import cmf_pkg::*;

   localparam int LINE_DEPTH    = 1024;   // DUT MAX_WIDTH
   localparam int ROWS_MAX      = 4096;   // DUT MAX_HEIGHT
   localparam int SETTLE_CYCLES = 20;     // allows for a pixel in flight plus the queue
   localparam int DRAIN_LIMIT   = 50000;
   localparam int RANDOM_ITEMS  = 110;

   typedef enum int {
      CONTENT_BINARY,   // 0/255 image, mostly set
      CONTENT_SPARSE,   // mostly zero, the odd random value
      CONTENT_GREY      // any 8-bit value
   } content_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the line stores, the raster position and the
   // registers, and keeps the results still owed by the block.
   // -------------------------------------------------------------------------
   class morph_scoreboard;
      logic [PIXEL_W-1:0]  far_line  [LINE_DEPTH];   // two rows up
      logic [PIXEL_W-1:0]  near_line [LINE_DEPTH];   // one row up
      int unsigned         col_pos;
      int unsigned         row_pos;
      logic                mode_reg;
      logic [FW_REG_W-1:0] width_reg;
      logic [FH_REG_W-1:0] height_reg;
      result_type          awaited[$];
      int unsigned         pixels_taken;
      int unsigned         results_checked;
      int unsigned         errors;

      function new();
         foreach (far_line[i]) begin
            far_line[i]  = '0;
            near_line[i] = '0;
         end
         col_pos    = 0;
         row_pos    = 0;
         mode_reg   = MODE_EROSION;
         width_reg  = FW_RESET;
         height_reg = FH_RESET;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_MODE:         mode_reg   = value[0];
            CSR_FRAME_WIDTH:  width_reg  = value[FW_REG_W-1:0];
            CSR_FRAME_HEIGHT: height_reg = value[FH_REG_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_size(int unsigned size, int unsigned top);
         if (size < MIN_DIM) return MIN_DIM;
         if (size > top) return top;
         return size;
      endfunction

      // erosion: low byte of the running product; dilation: any pixel set
      function logic [PIXEL_W-1:0] cross_value(logic [PIXEL_W-1:0] centre,
                                               logic [PIXEL_W-1:0] up,
                                               logic [PIXEL_W-1:0] down,
                                               logic [PIXEL_W-1:0] left,
                                               logic [PIXEL_W-1:0] right);
         logic [PIXEL_W-1:0]   factors [4];
         logic [2*PIXEL_W-1:0] product;
         logic [PIXEL_W-1:0]   acc;
         if (mode_reg == MODE_DILATION)
            return (|{centre, up, down, left, right}) ? PIXEL_ON : PIXEL_OFF;
         factors = '{up, down, left, right};
         acc = centre;
         foreach (factors[i]) begin
            product = acc * factors[i];
            acc     = product[PIXEL_W-1:0];
         end
         return acc;
      endfunction

      // Advance the raster position by one accepted pixel and queue the
      // results it completes: the pixel above it, and its own copy on the
      // last row.
      function void take_pixel(logic [PIXEL_W-1:0] pixel, logic starts_frame);
         int unsigned        w;
         int unsigned        h;
         int unsigned        col;
         int unsigned        row;
         int                 n;
         logic [PIXEL_W-1:0] centre;
         logic [PIXEL_W-1:0] value;
         result_type         outs [2];
         w = clamp_size(width_reg, LINE_DEPTH);
         h = clamp_size(height_reg, ROWS_MAX);
         n = 0;
         pixels_taken++;
         if (starts_frame) begin
            col_pos = 0;
            row_pos = 0;
         end
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         col = col_pos;
         row = row_pos;

         if (row >= 1) begin
            centre = near_line[col];
            // first row and edge columns are copied through
            if (row == 1 || col == 0 || col == w - 1)
               value = centre;
            else
               value = cross_value(centre, far_line[col], pixel,
                                   far_line[col-1], near_line[col+1]);
            outs[n].pixel  = value;
            outs[n].row    = OUT_ROW_W'(row - 1);
            outs[n].column = OUT_COL_W'(col);
            outs[n].last   = 1'b0;
            n++;
         end

         far_line[col]  = near_line[col];
         near_line[col] = pixel;

         if (row == h - 1) begin
            outs[n].pixel  = pixel;
            outs[n].row    = OUT_ROW_W'(row);
            outs[n].column = OUT_COL_W'(col);
            outs[n].last   = 1'b0;
            n++;
         end
         if (n > 0) outs[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) awaited.push_back(outs[i]);

         // wrap at row end and at frame end
         col_pos = col + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
                     $time, results_checked, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [31:0] data, logic last);
         result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual data %h last %b",
                     $time, data, last);
            errors++;
            return;
         end
         want = awaited.pop_front();
         results_checked++;
         compare_field("pixel",   want.pixel,  data[7:0]);
         compare_field("row",     want.row,    data[19:8]);
         compare_field("column",  want.column, data[29:20]);
         compare_field("padding", '0,          data[31:30]);
         compare_field("last",    want.last,   last);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT and bench state
   // -------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [31:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   morph_scoreboard board;
   int unsigned     tx_idle_pct;
   int unsigned     rx_stall_pct;
   int unsigned     csr_writes;
   int unsigned     phase_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   cross_morphology_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Driving tasks: inputs move on the falling edge, handshakes are sampled
   // on the rising edge.
   // -------------------------------------------------------------------------

   // Select the idling pattern of a phase: none, sender gaps, receiver
   // stalls, or a little of both.
   task automatic set_idling(input int unsigned which);
      case (which % 4)
         0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
         1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
         2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
         default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase
   endtask

   // Present one pixel, hold it until the transaction completes, then
   // hand it to the scoreboard.
   task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic starts_frame);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tuser  = starts_frame;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_pixel(value, starts_frame);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(posedge clock);
      board.write_register(index, value);
      csr_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Drop the request, let every owed result out, then allow for a pixel
   // that completes no result but may still be in flight.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIXEL_W-1:0] pick_pixel(content_type content);
      case (content)
         CONTENT_BINARY: return ($urandom_range(0, 3) != 0) ? PIXEL_ON : PIXEL_OFF;
         CONTENT_SPARSE: return ($urandom_range(0, 7) == 0) ?
                                PIXEL_W'($urandom_range(0, 255)) : PIXEL_OFF;
         default:        return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // One phase: settle, program all three registers, stream the pixels.
   // A frame start goes on the first pixel when asked, and on the pixel
   // at restart_at to break a frame part way through.
   task automatic run_phase(input logic mode_sel, input logic [CSR_DATA_W-1:0] width_val,
                            input logic [CSR_DATA_W-1:0] height_val, input int count,
                            input logic restart, input content_type content,
                            input int restart_at);
      wait_idle();
      write_csr(CSR_MODE, CSR_DATA_W'(mode_sel));
      write_csr(CSR_FRAME_WIDTH, width_val);
      write_csr(CSR_FRAME_HEIGHT, height_val);
      phase_count++;
      for (int i = 0; i < count; i++)
         send_pixel(pick_pixel(content), (i == 0 && restart) || i == restart_at);
   endtask

   // -------------------------------------------------------------------------
   // Result side: stall at random, check every completed transaction.
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(0, 99) >= rx_stall_pct);
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [PIXEL_W-1:0]    erosion_seq [16];
      logic [CSR_DATA_W-1:0] width_val;
      logic [CSR_DATA_W-1:0] height_val;
      int unsigned           random_sent;
      int unsigned           eff_w;
      int unsigned           eff_h;
      int unsigned           prev_w;
      int unsigned           pick;
      int                    count;
      int                    restart_at;
      int                    drain;
      logic                  restart;

      board        = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_MODE;
      csr_wdata    = '0;
      csr_writes   = 0;
      phase_count  = 0;
      random_sent  = 0;
      set_idling(0);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed erosion on a 3x3 frame; both sizes are written below the
      // minimum and clamp up. The frame holds the pixel extremes and every
      // bit in both states. Four more pixels follow without a frame start,
      // so the position wraps to the top by itself, then a frame start
      // lands mid-row.
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_EROSION));
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(2));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(0));
      phase_count++;
      erosion_seq = '{8'd255, 8'd1,   8'd128,
                      8'd127, 8'd255, 8'd170,
                      8'd85,  8'd254, 8'd0,
                      8'd255, 8'd255, 8'd255, 8'd255,
                      8'd255, 8'd0,   8'd255};
      foreach (erosion_seq[i])
         send_pixel(erosion_seq[i], i == 0 || i == 13);

      // Directed dilation: a single set pixel below the centre must light it.
      wait_idle();
      write_csr(CSR_MODE, CSR_DATA_W'(MODE_DILATION));
      phase_count++;
      for (int i = 0; i < 9; i++)
         send_pixel((i == 7) ? PIXEL_W'(1) : PIXEL_OFF, i == 0);

      // A wide frame with bursts of two results along the last row, then
      // an over-range width that clamps to the full line length.
      set_idling(1);
      run_phase(MODE_EROSION, CSR_DATA_W'(40), CSR_DATA_W'(2),
                3 * 40, 1'b1, CONTENT_BINARY, -1);
      set_idling(2);
      run_phase(MODE_DILATION, CSR_DATA_W'(2047), CSR_DATA_W'(3),
                24, 1'b1, CONTENT_SPARSE, -1);

      // Tallest frame, narrowest rows; then an over-range height that clamps
      // to the same value, carrying on mid-frame.
      set_idling(3);
      run_phase(MODE_EROSION, CSR_DATA_W'(3), CSR_DATA_W'(ROWS_MAX),
                30, 1'b1, CONTENT_GREY, -1);
      set_idling(0);
      run_phase(MODE_DILATION, CSR_DATA_W'(3), CSR_DATA_W'(8191),
                15, 1'b0, CONTENT_SPARSE, -1);

      // Random phases: mostly whole frames with random content, some run
      // on past the frame end, some cut by a stray frame start. A phase
      // carries on without a frame start only when the row length holds,
      // so no unwritten line entry is ever read.
      width_val = CSR_DATA_W'(3);
      prev_w    = 3;
      while (random_sent < RANDOM_ITEMS) begin
         set_idling(phase_count);
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 9);
            width_val = (pick == 0) ? CSR_DATA_W'($urandom_range(0, 2)) :
                        (pick == 1) ? CSR_DATA_W'(3) :
                        (pick < 8)  ? CSR_DATA_W'($urandom_range(4, 10)) :
                                      CSR_DATA_W'($urandom_range(11, 24));
         end
         pick = $urandom_range(0, 5);
         height_val = (pick == 0) ? CSR_DATA_W'($urandom_range(0, 2)) :
                      (pick == 1) ? CSR_DATA_W'(3) :
                                    CSR_DATA_W'($urandom_range(4, 6));
         eff_w   = (width_val < MIN_DIM) ? MIN_DIM : width_val;
         eff_h   = (height_val < MIN_DIM) ? MIN_DIM : height_val;
         restart = (eff_w != prev_w) || ($urandom_range(0, 1) == 1);
         count   = $urandom_range(eff_w * eff_h, 2 * eff_w * eff_h);
         // keep the whole run near its item budget
         if (count > int'(RANDOM_ITEMS - random_sent))
            count = int'(RANDOM_ITEMS - random_sent);
         restart_at = (count > 1 && $urandom_range(0, 3) == 0) ?
                      $urandom_range(1, count - 1) : -1;
         run_phase(1'($urandom_range(0, 1)), width_val, height_val, count, restart,
                   content_type'($urandom_range(0, 2)), restart_at);
         random_sent += count;
         prev_w = eff_w;
      end

      // Drain, then give any stray result time to show up.
      @(negedge clock);
      req_tvalid = 1'b0;
      drain = 0;
      while (board.pending() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0t: %0d results still owed at the end", $time, board.pending());
         board.errors++;
      end

      $display("Streamed %0d pixels in %0d phases, %0d results checked, %0d register writes.",
               board.pixels_taken, phase_count, board.results_checked, csr_writes);
      $display("Erosion and dilation, widths 3 to 1024 and heights 3 to 4096 with clamping,");
      $display("frame wrap, mid-frame restarts, sender gaps and receiver stalls.");
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
